### src/utf8cd_pkg.sv
// Shared types and constants for the UTF-8 code point decoder.
// No dependencies; used by every module of the block.
package utf8cd_pkg;

    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned CP_W           = 21;
    // Up to four replacements can come out of a single byte.
    localparam int unsigned REP_W          = 3;
    localparam int unsigned FIFO_DEPTH_DEF = 4;

    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    // One decoded job: a run of replacements, then an optional plain code point.
    typedef struct packed {
        logic [REP_W-1:0] reps;
        logic             tail_vld;
        logic [CP_W-1:0]  tail_cp;
        logic             fin;
    } t_job;

endpackage

### src/utf8cd_front.sv
// Front end: takes one byte per beat, tracks the open sequence, emits jobs.
// Depends on utf8cd_pkg.
module utf8cd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [utf8cd_pkg::BYTE_W-1:0] i_text_byte,
    input  logic                         i_final_byte,
    input  logic                         i_full,
    output logic                         o_stall,
    output logic                         o_push,
    output utf8cd_pkg::t_job             o_job
);
    import utf8cd_pkg::*;

    localparam logic [2:0] CLS_ASCII = 3'd0;
    localparam logic [2:0] CLS_TWO   = 3'd1;
    localparam logic [2:0] CLS_THREE = 3'd2;
    localparam logic [2:0] CLS_FOUR  = 3'd3;
    localparam logic [2:0] CLS_BAD   = 3'd4;

    logic [CP_W-1:0] r_partial, n_partial;
    logic [1:0]      r_needed,  n_needed;
    logic [1:0]      r_taken,   n_taken;
    logic [2:0]      cls;
    logic            is_cont;
    logic            accept;
    t_job            job;

    always_comb begin
        case (i_text_byte) inside
            [8'h00:8'h7F]: cls = CLS_ASCII;
            [8'hC0:8'hDF]: cls = CLS_TWO;
            [8'hE0:8'hEF]: cls = CLS_THREE;
            [8'hF0:8'hF7]: cls = CLS_FOUR;
            default:       cls = CLS_BAD;
        endcase
    end

    assign is_cont = (i_text_byte[7:6] == 2'b10);

    always_comb begin
        n_partial = r_partial;
        n_needed  = r_needed;
        n_taken   = r_taken;
        job       = '0;
        if ((r_needed != 2'd0) && is_cont) begin
            n_partial = {r_partial[CP_W-7:0], i_text_byte[5:0]};
            n_needed  = r_needed - 2'd1;
            n_taken   = r_taken + 2'd1;
            if (n_needed == 2'd0) begin
                job.tail_vld = 1'b1;
                job.tail_cp  = n_partial;
                n_partial    = '0;
                n_taken      = 2'd0;
            end
        end else begin
            // no open sequence, or a broken one: lead plus taken continuations are replaced; then scan as lead
            if (r_needed != 2'd0) begin
                job.reps = {1'b0, r_taken} + 3'd1;
            end
            n_partial = '0;
            n_needed  = 2'd0;
            n_taken   = 2'd0;
            case (cls)
                CLS_ASCII: begin
                    job.tail_vld = 1'b1;
                    job.tail_cp  = CP_W'(i_text_byte);
                end
                CLS_TWO: begin
                    n_needed  = 2'd1;
                    n_partial = CP_W'(i_text_byte[4:0]);
                end
                CLS_THREE: begin
                    n_needed  = 2'd2;
                    n_partial = CP_W'(i_text_byte[3:0]);
                end
                CLS_FOUR: begin
                    n_needed  = 2'd3;
                    n_partial = CP_W'(i_text_byte[2:0]);
                end
                default: begin
                    job.reps = job.reps + 3'd1;
                end
            endcase
        end
        if (i_final_byte) begin
            // truncated text
            if (n_needed != 2'd0) begin
                job.reps = job.reps + {1'b0, n_taken} + 3'd1;
            end
            n_partial = '0;
            n_needed  = 2'd0;
            n_taken   = 2'd0;
        end
        job.fin = i_final_byte;
    end

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign o_push  = accept && ((job.reps != '0) || job.tail_vld);
    assign o_job   = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_needed  <= 2'd0;
            r_taken   <= 2'd0;
        end else if (accept) begin
            r_partial <= n_partial;
            r_needed  <= n_needed;
            r_taken   <= n_taken;
        end
    end

endmodule

### src/utf8cd_fifo.sv
// Small job queue between the front and back ends.
// Depends on utf8cd_pkg.
module utf8cd_fifo #(
    parameter int unsigned DEPTH = utf8cd_pkg::FIFO_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  utf8cd_pkg::t_job i_job,
    input  logic             i_pop,
    output utf8cd_pkg::t_job o_head,
    output logic             o_full,
    output logic             o_empty
);
    import utf8cd_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == FULL);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### src/utf8cd_back.sv
// Back end: expands one job into result beats through an output register.
// Depends on utf8cd_pkg.
module utf8cd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  utf8cd_pkg::t_job            i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [utf8cd_pkg::CP_W-1:0] o_code_point,
    output logic                        o_is_replacement,
    output logic                        o_run_end,
    output logic                        o_text_end
);
    import utf8cd_pkg::*;

    logic            r_busy;
    t_job            r_job;
    t_job            src, rest;
    logic            src_vld, load, first_rep, last;
    logic            r_out_vld;
    logic [CP_W-1:0] r_cp;
    logic            r_rep, r_run_end, r_text_end;

    assign src       = r_busy ? r_job : i_head;
    assign src_vld   = r_busy || !i_empty;
    assign load      = src_vld && (!r_out_vld || !i_stall);
    assign first_rep = (src.reps != '0);
    assign last      = first_rep ? ((src.reps == 3'd1) && !src.tail_vld) : 1'b1;
    assign o_pop     = load && !r_busy;

    always_comb begin
        rest = src;
        if (first_rep) begin
            rest.reps = src.reps - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_busy    <= !last;
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job      <= rest;
            r_cp       <= first_rep ? REPL_CP : src.tail_cp;
            r_rep      <= first_rep;
            r_run_end  <= last;
            r_text_end <= last && src.fin;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_code_point     = r_cp;
    assign o_is_replacement = r_rep;
    assign o_run_end        = r_run_end;
    assign o_text_end       = r_text_end;

endmodule

### src/utf8_codepoint_decoder.sv
// Top level of the UTF-8 code point decoder with U+FFFD replacement.
// Depends on utf8cd_pkg, utf8cd_front, utf8cd_fifo and utf8cd_back.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  input   | in        | i_valid / o_stall  | i_text_byte[7:0], i_final_byte
//  output  | out       | o_valid / i_stall  | o_code_point[20:0], o_is_replacement,
//          |           |                    | o_run_end, o_text_end
//
// The front end takes one byte per cycle while o_stall is low, with its decode state
// updated at once; o_stall rises only when the job queue is full.
// A byte that yields n results (n is 0 to 4) holds the back end for one beat per
// result; a byte that only opens or extends a sequence costs the back end nothing.
// Results leave through a registered output stage, so a stalled output beat holds
// while the queue keeps filling.
// Reset (i_rst_n low, synchronous) clears the decode state, queue and output valid.
module utf8_codepoint_decoder #(
    parameter int unsigned FIFO_DEPTH = utf8cd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [utf8cd_pkg::BYTE_W-1:0] i_text_byte,
    input  logic                          i_final_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [utf8cd_pkg::CP_W-1:0]   o_code_point,
    output logic                          o_is_replacement,
    output logic                          o_run_end,
    output logic                          o_text_end
);
    import utf8cd_pkg::*;

    t_job push_job, head_job;
    logic push, pop, full, empty;

    // classify bytes and keep the partial code point
    utf8cd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .i_full       (full),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_job        (push_job)
    );

    // decouples byte intake from replacement bursts
    utf8cd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    // one result beat per cycle while the output is not stalled
    utf8cd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_head           (head_job),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_code_point     (o_code_point),
        .o_is_replacement (o_is_replacement),
        .o_run_end        (o_run_end),
        .o_text_end       (o_text_end)
    );

endmodule

### tb/utf8_codepoint_decoder_tb.sv
// Self-checking bench for utf8_codepoint_decoder: a code point scoreboard plus drivers
// for the byte and result channels. Depends on utf8cd_pkg and the decoder RTL.
module utf8_codepoint_decoder_tb;
    import utf8cd_pkg::*;

    // Decodes each accepted byte on the side and queues the beats it should produce.
    class codepoint_scoreboard;
        typedef struct packed {
            logic [CP_W-1:0] cp;
            logic            repl;
            logic            run_last;
            logic            text_last;
        } t_cp_beat;

        logic [CP_W-1:0] partial;
        logic [1:0]      needed;
        logic [1:0]      taken;
        t_cp_beat        expected_cps[$];
        t_cp_beat        step_beats[$];
        int              errors;

        function new();
            clear_decode();
            errors = 0;
        endfunction

        function void clear_decode();
            partial = '0;
            needed  = 2'd0;
            taken   = 2'd0;
        endfunction

        function void add_beat(logic [CP_W-1:0] cp, logic repl);
            t_cp_beat b;
            b.cp        = cp;
            b.repl      = repl;
            b.run_last  = 1'b0;
            b.text_last = 1'b0;
            step_beats  = {step_beats, b};
        endfunction

        // Broken or truncated sequence: one U+FFFD for the lead plus one per
        // continuation byte already consumed.
        function void flush_open();
            for (int i = 0; i <= int'(taken); i++)
                add_beat(REPL_CP, 1'b1);
            clear_decode();
        endfunction

        function void take_lead(logic [BYTE_W-1:0] b);
            taken = 2'd0;
            if (b[7] == 1'b0) begin
                add_beat(CP_W'(b), 1'b0);
            end else if (b[7:5] == 3'b110) begin
                needed  = 2'd1;
                partial = CP_W'(b[4:0]);
            end else if (b[7:4] == 4'b1110) begin
                needed  = 2'd2;
                partial = CP_W'(b[3:0]);
            end else if (b[7:3] == 5'b11110) begin
                needed  = 2'd3;
                partial = CP_W'(b[2:0]);
            end else begin
                // stray continuation or F8..FF
                add_beat(REPL_CP, 1'b1);
            end
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b, logic fin);
            bit consumed;
            consumed = 1'b0;
            step_beats.delete();
            if (needed != 2'd0) begin
                if (b[7:6] == 2'b10) begin
                    partial = {partial[CP_W-7:0], b[5:0]};
                    needed  = needed - 2'd1;
                    taken   = taken + 2'd1;
                    if (needed == 2'd0) begin
                        add_beat(partial, 1'b0);
                        partial = '0;
                        taken   = 2'd0;
                    end
                    consumed = 1'b1;
                end else begin
                    flush_open();
                end
            end
            // the breaking byte is rescanned as a lead
            if (!consumed)
                take_lead(b);
            if (fin) begin
                if (needed != 2'd0)
                    flush_open();
                clear_decode();
            end
            if (step_beats.size() > 0) begin
                step_beats[step_beats.size() - 1].run_last  = 1'b1;
                step_beats[step_beats.size() - 1].text_last = fin;
            end
            foreach (step_beats[i])
                expected_cps = {expected_cps, step_beats[i]};
        endfunction

        function void check_cp(logic [CP_W-1:0] cp, logic repl, logic run_last,
                               logic text_last);
            t_cp_beat e;
            if (expected_cps.size() == 0) begin
                $error("unexpected result beat: code_point %0h", cp);
                errors++;
                return;
            end
            e = expected_cps.pop_front();
            if (cp !== e.cp) begin
                $error("code_point: expected %0h, got %0h", e.cp, cp);
                errors++;
            end
            if (repl !== e.repl) begin
                $error("is_replacement: expected %0b, got %0b", e.repl, repl);
                errors++;
            end
            if (run_last !== e.run_last) begin
                $error("run_end: expected %0b, got %0b", e.run_last, run_last);
                errors++;
            end
            if (text_last !== e.text_last) begin
                $error("text_end: expected %0b, got %0b", e.text_last, text_last);
                errors++;
            end
        endfunction
    endclass

    localparam int RANDOM_BYTES = 144;
    localparam int HOLD_CYCLES  = 120;

    // Directed text: bit 8 is the final-byte flag.
    localparam logic [8:0] DIRECTED [26] = '{
        9'h000, 9'h07F,                   // ASCII extremes
        9'h0E2, 9'h082, 9'h0AC,           // three-byte sequence
        9'h0F0, 9'h09F, 9'h098, 9'h080,   // four-byte sequence
        9'h0EF, 9'h0BF, 9'h0BD,           // genuine U+FFFD, not a replacement
        9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,   // largest 21-bit value
        9'h080, 9'h0FF,                   // bad leads
        9'h0E2, 9'h082, 9'h041,           // broken after one continuation
        9'h1C3,                           // text ends on an open lead
        9'h0F0, 9'h09F, 9'h098, 9'h1FF    // broken at the end: four beats from one byte
    };

    logic                i_clk;
    logic                i_rst_n          = 1'b0;
    logic                i_valid          = 1'b0;
    logic                o_stall;
    logic [BYTE_W-1:0]   i_text_byte      = '0;
    logic                i_final_byte     = 1'b0;
    logic                o_valid;
    logic                i_stall          = 1'b0;
    logic [CP_W-1:0]     o_code_point;
    logic                o_is_replacement;
    logic                o_run_end;
    logic                o_text_end;

    codepoint_scoreboard sb;
    int                  bytes_sent = 0;
    bit                  no_idle    = 1'b0;
    bit                  long_hold  = 1'b0;
    bit                  hold_done  = 1'b0;

    utf8_codepoint_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_text_byte     (i_text_byte),
        .i_final_byte    (i_final_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_code_point    (o_code_point),
        .o_is_replacement(o_is_replacement),
        .o_run_end       (o_run_end),
        .o_text_end      (o_text_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_400_000;
        $display("TEST FAILED");
        $finish;
    end

    // Offer one byte after a random gap and hold it until the decoder takes it.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_text_byte  <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_byte(b, fin);
        bytes_sent++;
    endtask

    // Mostly well-formed characters with random payload bits; the rest are bad leads,
    // truncated sequences and raw noise. The final flag lands anywhere.
    task automatic send_random_char();
        logic [BYTE_W-1:0] seq[$];
        int                kind;
        int                len;
        int                keep;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            seq = {seq, BYTE_W'($urandom_range(0, 127))};
        end else if (kind < 90) begin
            len = $urandom_range(2, 4);
            case (len)
                2: seq = {seq, {3'b110, 5'($urandom)}};
                3: seq = {seq, {4'b1110, 4'($urandom)}};
                default: seq = {seq, {5'b11110, 3'($urandom)}};
            endcase
            keep = (kind < 80) ? len - 1 : $urandom_range(0, len - 2);
            repeat (keep) seq = {seq, {2'b10, 6'($urandom)}};
            if (kind >= 80)
                seq = {seq, BYTE_W'($urandom)};
        end else if (kind < 95) begin
            if ($urandom_range(0, 1) == 0)
                seq = {seq, {2'b10, 6'($urandom)}};
            else
                seq = {seq, {5'b11111, 3'($urandom)}};
        end else begin
            seq = {seq, BYTE_W'($urandom)};
        end
        foreach (seq[i])
            send_byte(seq[i], $urandom_range(0, 19) == 0);
    endtask

    // Result side: random stall before each beat, plus one long hold-off on request.
    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 6);
            if (long_hold) begin
                long_hold = 1'b0;
                n = HOLD_CYCLES;
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            sb.check_cp(o_code_point, o_is_replacement, o_run_end, o_text_end);
        end
    end

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

        while (bytes_sent < $size(DIRECTED) + RANDOM_BYTES) begin
            // back-to-back stretch; the receiver hold-off inside it fills the queue
            no_idle = (bytes_sent >= 80 && bytes_sent < 130);
            if (bytes_sent >= 95 && !hold_done) begin
                hold_done = 1'b1;
                long_hold = 1'b1;
            end
            send_random_char();
        end
        i_valid <= 1'b0;

        while (sb.expected_cps.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_cps.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
